// ----- sv/xyzfbi_pkg.sv -----
// Shared constants for the extended XYZ frame boundary indexer.
// No dependencies; every file but xyzfbi_in_if and xyzfbi_in_stage imports this package.
`default_nettype none

package xyzfbi_pkg;

	// Default widths of byte offsets and of the signed atom count
	localparam int OFFSET_BITS_DEF = 32;
	localparam int COUNT_BITS_DEF  = 24;

	// Character codes the scanner reacts to
	localparam logic [7:0] CH_NEWLINE = 8'h0A;
	localparam logic [7:0] CH_TAB     = 8'h09;
	localparam logic [7:0] CH_CR      = 8'h0D;
	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_PLUS    = 8'h2B;
	localparam logic [7:0] CH_MINUS   = 8'h2D;
	localparam logic [7:0] CH_ZERO    = 8'h30;
	localparam logic [7:0] CH_NINE    = 8'h39;

endpackage

`default_nettype wire

// ----- sv/xyzfbi_in_if.sv -----
// Byte channel into the frame indexer: valid/ready handshake plus one text byte.
// Depends on nothing.
`default_nettype none

interface xyzfbi_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] text_byte;
	logic       final_byte;

	modport source (output valid, output text_byte, output final_byte, input ready);
	modport sink   (input valid, input text_byte, input final_byte, output ready);
endinterface

`default_nettype wire

// ----- sv/xyzfbi_out_if.sv -----
// Frame record channel out of the frame indexer: valid/ready handshake plus offsets and count.
// Depends on xyzfbi_pkg for default widths.
`default_nettype none

interface xyzfbi_out_if
	import xyzfbi_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic [OFFSET_BITS-1:0]        count_line_offset;
	logic [OFFSET_BITS-1:0]        header_offset;
	logic [OFFSET_BITS-1:0]        data_offset;
	logic [OFFSET_BITS-1:0]        frame_end_offset;
	logic signed [COUNT_BITS-1:0]  atom_count;

	modport source (
		output valid, output count_line_offset, output header_offset,
		output data_offset, output frame_end_offset, output atom_count, input ready
	);
	modport sink (
		input valid, input count_line_offset, input header_offset,
		input data_offset, input frame_end_offset, input atom_count, output ready
	);
endinterface

`default_nettype wire

// ----- sv/xyzfbi_in_stage.sv -----
// Input register of the frame indexer: captures one byte item per cycle unless the held byte is stalled.
// Depends on xyzfbi_in_if.
`default_nettype none

module xyzfbi_in_stage (
	input  wire logic     clk,
	input  wire logic     arst_n,
	xyzfbi_in_if.sink     feed,
	input  wire logic     go,
	output logic          valid_s1,
	output logic [7:0]    byte_s1,
	output logic          final_s1
);

	// Take a new item whenever the held one is empty or moves on this cycle
	assign feed.ready = !valid_s1 || go;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (feed.ready) begin
			valid_s1 <= feed.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (feed.ready && feed.valid) begin
			byte_s1  <= feed.text_byte;
			final_s1 <= feed.final_byte;
		end
	end

endmodule

`default_nettype wire

// ----- sv/xyzfbi_scanner.sv -----
// Line scanner of the frame indexer: holds the parse state and decides, per byte,
// whether a frame record is complete and what its fields are. Depends on xyzfbi_pkg.
`default_nettype none

module xyzfbi_scanner
	import xyzfbi_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     step,
	input  wire logic [7:0]               text_byte,
	input  wire logic                     final_byte,
	output logic                          emit,
	output logic [OFFSET_BITS-1:0]        count_line_offset,
	output logic [OFFSET_BITS-1:0]        header_offset,
	output logic [OFFSET_BITS-1:0]        data_offset,
	output logic [OFFSET_BITS-1:0]        frame_end_offset,
	output logic signed [COUNT_BITS-1:0]  atom_count
);

	localparam int MAG_BITS = COUNT_BITS - 1;
	localparam int PROD_BITS = MAG_BITS + 4;

	typedef enum logic [1:0] {PH_COUNT, PH_SKIP, PH_HEADER, PH_DATA} phase_t;
	typedef enum logic [1:0] {NP_SPACE, NP_SIGN, NP_DIGITS, NP_TAIL} num_phase_t;

	phase_t                 phase_q, phase_n;
	num_phase_t             nump_q, nump_u, nump_c;
	logic                   neg_q, neg_u;
	logic [MAG_BITS-1:0]    cnt_q, cnt_u;
	logic [MAG_BITS-1:0]    lines_q, lines_n, lines_dec;
	logic [OFFSET_BITS-1:0] pos_q, nxt;
	logic [OFFSET_BITS-1:0] frame_q, frame_n;
	logic [OFFSET_BITS-1:0] header_q, header_n;
	logic [OFFSET_BITS-1:0] data_q, data_n;
	logic                   clr;
	logic                   emit_step;
	logic                   from_data;
	logic                   fin_emit;
	logic                   is_digit;
	logic [3:0]             digit;
	logic [PROD_BITS-1:0]   prod;
	logic [COUNT_BITS-1:0]  cnt_ext;

	assign nxt = (pos_q == {OFFSET_BITS{1'b1}}) ? pos_q : pos_q + 1'b1;

	assign is_digit = (text_byte >= CH_ZERO) && (text_byte <= CH_NINE);
	assign digit    = 4'(text_byte - CH_ZERO);
	// count*10 + digit overflows the magnitude exactly when it exceeds the max
	assign prod     = PROD_BITS'(cnt_q) * PROD_BITS'(10) + PROD_BITS'(digit);

	assign lines_dec = (lines_q != '0) ? lines_q - 1'b1 : lines_q;

	always_comb begin
		phase_n   = phase_q;
		nump_u    = nump_q;
		neg_u     = neg_q;
		cnt_u     = cnt_q;
		lines_n   = lines_q;
		frame_n   = frame_q;
		header_n  = header_q;
		data_n    = data_q;
		clr       = 1'b0;
		emit_step = 1'b0;
		from_data = 1'b0;
		unique case (phase_q)
			PH_COUNT: begin
				if (text_byte == CH_NEWLINE) begin
					if (nump_q == NP_DIGITS || nump_q == NP_TAIL) begin
						phase_n  = PH_HEADER;
						header_n = nxt;
					end else begin
						clr     = 1'b1;
						frame_n = nxt;
					end
				end else if (is_digit) begin
					if (nump_q != NP_TAIL) begin
						if (prod[PROD_BITS-1:MAG_BITS] != '0) begin
							cnt_u = {MAG_BITS{1'b1}};
						end else begin
							cnt_u = prod[MAG_BITS-1:0];
						end
						nump_u = NP_DIGITS;
					end
				end else if (nump_q == NP_DIGITS || nump_q == NP_TAIL) begin
					nump_u = NP_TAIL;
				end else if (nump_q == NP_SPACE && (text_byte == CH_SPACE
						|| text_byte == CH_TAB || text_byte == CH_CR)) begin
					// leading whitespace: hold
				end else if (nump_q == NP_SPACE && (text_byte == CH_PLUS
						|| text_byte == CH_MINUS)) begin
					neg_u  = (text_byte == CH_MINUS);
					nump_u = NP_SIGN;
				end else begin
					phase_n = PH_SKIP;
				end
			end
			PH_SKIP: begin
				if (text_byte == CH_NEWLINE) begin
					phase_n = PH_COUNT;
					clr     = 1'b1;
					frame_n = nxt;
				end
			end
			PH_HEADER: begin
				if (text_byte == CH_NEWLINE) begin
					data_n = nxt;
					if (neg_q || cnt_q == '0) begin
						emit_step = 1'b1;
						phase_n   = PH_COUNT;
						clr       = 1'b1;
						frame_n   = nxt;
					end else begin
						lines_n = cnt_q;
						phase_n = PH_DATA;
					end
				end
			end
			PH_DATA: begin
				if (text_byte == CH_NEWLINE) begin
					lines_n = lines_dec;
					if (lines_dec == '0) begin
						emit_step = 1'b1;
						from_data = 1'b1;
						phase_n   = PH_COUNT;
						clr       = 1'b1;
						frame_n   = nxt;
					end
				end
			end
			default: begin
				phase_n = PH_COUNT;
			end
		endcase
	end

	assign nump_c = clr ? NP_SPACE : nump_u;

	// Close a pending frame at the buffer end
	assign fin_emit = final_byte && !emit_step && (
		(phase_n == PH_COUNT && (nump_c == NP_DIGITS || nump_c == NP_TAIL))
		|| phase_n == PH_HEADER || phase_n == PH_DATA);

	assign emit = emit_step || fin_emit;

	assign cnt_ext           = {1'b0, cnt_u};
	assign count_line_offset = frame_q;
	assign header_offset     = (fin_emit && phase_n == PH_COUNT) ? nxt : header_n;
	assign data_offset       = (from_data || (fin_emit && phase_n == PH_DATA)) ? data_n : nxt;
	assign frame_end_offset  = nxt;
	assign atom_count        = $signed(neg_u ? -cnt_ext : cnt_ext);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= PH_COUNT;
			nump_q   <= NP_SPACE;
			neg_q    <= 1'b0;
			cnt_q    <= '0;
			lines_q  <= '0;
			pos_q    <= '0;
			frame_q  <= '0;
			header_q <= '0;
			data_q   <= '0;
		end else if (step) begin
			if (final_byte) begin
				// Start a new buffer at offset zero
				phase_q  <= PH_COUNT;
				nump_q   <= NP_SPACE;
				neg_q    <= 1'b0;
				cnt_q    <= '0;
				lines_q  <= '0;
				pos_q    <= '0;
				frame_q  <= '0;
				header_q <= '0;
				data_q   <= '0;
			end else begin
				phase_q  <= phase_n;
				nump_q   <= nump_c;
				neg_q    <= clr ? 1'b0 : neg_u;
				cnt_q    <= clr ? '0 : cnt_u;
				lines_q  <= lines_n;
				pos_q    <= nxt;
				frame_q  <= frame_n;
				header_q <= header_n;
				data_q   <= data_n;
			end
		end
	end

endmodule

`default_nettype wire

// ----- sv/xyzfbi_out_stage.sv -----
// Result register of the frame indexer: holds one frame record until taken.
// Depends on xyzfbi_pkg and xyzfbi_out_if.
`default_nettype none

module xyzfbi_out_stage
	import xyzfbi_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           load,
	input  wire logic [OFFSET_BITS-1:0]         count_line_offset,
	input  wire logic [OFFSET_BITS-1:0]         header_offset,
	input  wire logic [OFFSET_BITS-1:0]         data_offset,
	input  wire logic [OFFSET_BITS-1:0]         frame_end_offset,
	input  wire logic signed [COUNT_BITS-1:0]   atom_count,
	output logic                                free,
	xyzfbi_out_if.source                        frames
);

	logic                         valid_q;
	logic [OFFSET_BITS-1:0]       count_line_q;
	logic [OFFSET_BITS-1:0]       header_q;
	logic [OFFSET_BITS-1:0]       data_q;
	logic [OFFSET_BITS-1:0]       end_q;
	logic signed [COUNT_BITS-1:0] count_q;

	assign free = !valid_q || frames.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (frames.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			count_line_q <= count_line_offset;
			header_q     <= header_offset;
			data_q       <= data_offset;
			end_q        <= frame_end_offset;
			count_q      <= atom_count;
		end
	end

	assign frames.valid             = valid_q;
	assign frames.count_line_offset = count_line_q;
	assign frames.header_offset     = header_q;
	assign frames.data_offset       = data_q;
	assign frames.frame_end_offset  = end_q;
	assign frames.atom_count        = count_q;

endmodule

`default_nettype wire

// ----- sv/xyz_frame_boundary_indexer.sv -----
// Frame boundary indexer for extended XYZ text. Feed the buffer one byte per item on
// feed, with final_byte set on its last byte; each complete frame comes out on frames
// as its count line, header, data and end offsets and the signed atom count. The block
// takes one byte per cycle unless stalled: a byte passes an input register, the line
// scanner and the result register, and a record is loaded into the result register when
// the scanner steps on the byte closing it. The only stall comes from a record held in
// the result register and not yet taken. After final_byte all offsets restart at zero for the next buffer.
`default_nettype none

module xyz_frame_boundary_indexer
	import xyzfbi_pkg::*;
#(
	parameter int OFFSET_BITS = OFFSET_BITS_DEF,
	parameter int COUNT_BITS  = COUNT_BITS_DEF
) (
	input  wire logic      clk,
	input  wire logic      arst_n,
	xyzfbi_in_if.sink      feed,
	xyzfbi_out_if.source   frames
);

	logic                         valid_s1;
	logic [7:0]                   byte_s1;
	logic                         final_s1;
	logic                         go;
	logic                         out_free;
	logic                         emit;
	logic [OFFSET_BITS-1:0]       count_line_offset;
	logic [OFFSET_BITS-1:0]       header_offset;
	logic [OFFSET_BITS-1:0]       data_offset;
	logic [OFFSET_BITS-1:0]       frame_end_offset;
	logic signed [COUNT_BITS-1:0] atom_count;

	// Advance the held byte when the result register can take a record
	assign go = valid_s1 && out_free;

	xyzfbi_in_stage u_in_stage (
		.clk      (clk),
		.arst_n   (arst_n),
		.feed     (feed),
		.go       (go),
		.valid_s1 (valid_s1),
		.byte_s1  (byte_s1),
		.final_s1 (final_s1)
	);

	xyzfbi_scanner #(
		.OFFSET_BITS (OFFSET_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_scanner (
		.clk               (clk),
		.arst_n            (arst_n),
		.step              (go),
		.text_byte         (byte_s1),
		.final_byte        (final_s1),
		.emit              (emit),
		.count_line_offset (count_line_offset),
		.header_offset     (header_offset),
		.data_offset       (data_offset),
		.frame_end_offset  (frame_end_offset),
		.atom_count        (atom_count)
	);

	xyzfbi_out_stage #(
		.OFFSET_BITS (OFFSET_BITS),
		.COUNT_BITS  (COUNT_BITS)
	) u_out_stage (
		.clk               (clk),
		.arst_n            (arst_n),
		.load              (go && emit),
		.count_line_offset (count_line_offset),
		.header_offset     (header_offset),
		.data_offset       (data_offset),
		.frame_end_offset  (frame_end_offset),
		.atom_count        (atom_count),
		.free              (out_free),
		.frames            (frames)
	);

endmodule

`default_nettype wire

// ----- bench/testbench.sv -----
// Self-checking bench for xyz_frame_boundary_indexer: streams random and directed text
// buffers through the byte channel and compares each frame record with an in-bench scanner.
// Depends on xyzfbi_pkg, xyzfbi_in_if, xyzfbi_out_if and the indexer RTL.
`default_nettype none

module testbench;
	import xyzfbi_pkg::*;

	localparam int OB          = OFFSET_BITS_DEF;
	localparam int CB          = COUNT_BITS_DEF;
	localparam int CNT_MAX     = 2 ** (CB - 1) - 1;
	localparam int HOLD_LEN    = 300;
	localparam int STALL_LIMIT = 4000;

	typedef enum logic [1:0] {SCAN_COUNT, SCAN_SKIP, SCAN_HEADER, SCAN_DATA} scan_phase_t;
	typedef enum logic [1:0] {NUM_LEAD, NUM_SIGN, NUM_DIGITS, NUM_TAIL} num_phase_t;

	typedef struct packed {
		logic [7:0] b;
		logic       fin;
	} text_item_t;

	typedef struct packed {
		logic [OB-1:0]        line_at;
		logic [OB-1:0]        head_at;
		logic [OB-1:0]        data_at;
		logic [OB-1:0]        end_at;
		logic signed [CB-1:0] atoms;
	} frame_rec_t;

	logic clk = 1'b0;
	logic arst_n;

	xyzfbi_in_if  feed_if ();
	xyzfbi_out_if frames_if ();

	xyz_frame_boundary_indexer u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.feed   (feed_if),
		.frames (frames_if)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	// Scanner state
	scan_phase_t   scan_ph;
	num_phase_t    num_ph;
	logic          neg_sign;
	logic [CB-1:0] count_acc;
	logic [CB-1:0] lines_todo;
	logic [OB-1:0] pos;
	logic [OB-1:0] frame_at;
	logic [OB-1:0] header_at;
	logic [OB-1:0] data_at;

	text_item_t pend_q[$];
	frame_rec_t frame_q[$];
	logic [7:0] draft[$];

	int sent_cnt      = 0;
	int taken_cnt     = 0;
	int bytes_queued  = 0;
	int buffers_sent  = 0;
	int records_ok    = 0;
	int nonpos_frames = 0;
	int errors        = 0;
	int stall_cycles  = 0;
	int snd_idle_pct  = 0;
	int rcv_idle_pct  = 0;
	int hold_req_seq  = 0;
	int hold_seen_seq = 0;
	int hold_left     = 0;

	// Append one byte to the buffer under construction
	task automatic draft_put(input logic [7:0] v);
		draft = {draft, v};
	endtask

	task automatic num_clear();
		num_ph    = NUM_LEAD;
		neg_sign  = 1'b0;
		count_acc = '0;
	endtask

	task automatic scan_reset();
		scan_ph    = SCAN_COUNT;
		num_clear();
		lines_todo = '0;
		pos        = '0;
		frame_at   = '0;
		header_at  = '0;
		data_at    = '0;
	endtask

	task automatic restart_line(input logic [OB-1:0] at);
		scan_ph  = SCAN_COUNT;
		num_clear();
		frame_at = at;
	endtask

	task automatic add_expected(input logic [OB-1:0] hdr, input logic [OB-1:0] dat,
			input logic [OB-1:0] fend);
		frame_rec_t r;
		logic [CB-1:0] c;
		c = neg_sign ? -count_acc : count_acc;
		r.line_at = frame_at;
		r.head_at = hdr;
		r.data_at = dat;
		r.end_at  = fend;
		r.atoms   = c;
		frame_q = {frame_q, r};
	endtask

	// Advance the line scanner by one byte and queue any frame record it closes
	task automatic scan_byte(input logic [7:0] b, input logic fin);
		logic [OB-1:0] nxt;
		int d;
		bit done;
		nxt  = (pos == {OB{1'b1}}) ? pos : pos + 1'b1;
		done = 1'b0;
		case (scan_ph)
			SCAN_COUNT: begin
				if (b == CH_NEWLINE) begin
					if (num_ph == NUM_DIGITS || num_ph == NUM_TAIL) begin
						scan_ph   = SCAN_HEADER;
						header_at = nxt;
					end else begin
						restart_line(nxt);
					end
				end else if (b >= CH_ZERO && b <= CH_NINE) begin
					if (num_ph != NUM_TAIL) begin
						d = int'(b - CH_ZERO);
						if (count_acc > (CNT_MAX - d) / 10)
							count_acc = CB'(CNT_MAX);
						else
							count_acc = CB'(count_acc * 10 + d);
						num_ph = NUM_DIGITS;
					end
				end else if (num_ph == NUM_DIGITS || num_ph == NUM_TAIL) begin
					num_ph = NUM_TAIL;
				end else if (num_ph == NUM_LEAD
						&& (b == CH_SPACE || b == CH_TAB || b == CH_CR)) begin
					// hold through leading whitespace
				end else if (num_ph == NUM_LEAD && (b == CH_PLUS || b == CH_MINUS)) begin
					neg_sign = (b == CH_MINUS);
					num_ph   = NUM_SIGN;
				end else begin
					scan_ph = SCAN_SKIP;
				end
			end
			SCAN_SKIP: begin
				if (b == CH_NEWLINE)
					restart_line(nxt);
			end
			SCAN_HEADER: begin
				if (b == CH_NEWLINE) begin
					data_at = nxt;
					if (neg_sign || count_acc == 0) begin
						add_expected(header_at, nxt, nxt);
						done = 1'b1;
						restart_line(nxt);
					end else begin
						lines_todo = count_acc;
						scan_ph    = SCAN_DATA;
					end
				end
			end
			default: begin
				if (b == CH_NEWLINE) begin
					if (lines_todo > 0)
						lines_todo--;
					if (lines_todo == 0) begin
						add_expected(header_at, data_at, nxt);
						done = 1'b1;
						restart_line(nxt);
					end
				end
			end
		endcase
		pos = nxt;

		// Close a pending frame at the buffer end, then start the next buffer at zero
		if (fin) begin
			if (!done) begin
				if (scan_ph == SCAN_COUNT && (num_ph == NUM_DIGITS || num_ph == NUM_TAIL))
					add_expected(nxt, nxt, nxt);
				else if (scan_ph == SCAN_HEADER)
					add_expected(header_at, nxt, nxt);
				else if (scan_ph == SCAN_DATA)
					add_expected(header_at, data_at, nxt);
			end
			scan_reset();
		end
	endtask

	task automatic check_field(input string fname, input longint want_v, input longint got_v);
		if (want_v != got_v) begin
			$display("%0t: %s expected %0d got %0d", $time, fname, want_v, got_v);
			errors++;
		end
	endtask

	// Sender: present the next pending item once the previous one is taken
	always @(negedge clk) begin : driver
		text_item_t itm;
		if (arst_n && taken_cnt == sent_cnt) begin
			if (pend_q.size() == 0 || $urandom_range(99) < snd_idle_pct) begin
				feed_if.valid <= 1'b0;
			end else begin
				itm = pend_q.pop_front();
				feed_if.text_byte  <= itm.b;
				feed_if.final_byte <= itm.fin;
				feed_if.valid      <= 1'b1;
				sent_cnt++;
			end
		end
	end

	// Receiver: random back-pressure plus a long hold on request
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_req_seq != hold_seen_seq) begin
				hold_seen_seq = hold_req_seq;
				hold_left     = HOLD_LEN;
			end
			if (hold_left > 0) begin
				hold_left--;
				frames_if.ready <= 1'b0;
			end else begin
				frames_if.ready <= ($urandom_range(99) >= rcv_idle_pct);
			end
		end
	end

	always @(posedge clk) begin : monitor
		frame_rec_t got;
		frame_rec_t want;
		bit moved;
		if (arst_n) begin
			moved = 1'b0;
			if (feed_if.valid && feed_if.ready) begin
				scan_byte(feed_if.text_byte, feed_if.final_byte);
				taken_cnt++;
				moved = 1'b1;
			end
			if (frames_if.valid && frames_if.ready) begin
				moved       = 1'b1;
				got.line_at = frames_if.count_line_offset;
				got.head_at = frames_if.header_offset;
				got.data_at = frames_if.data_offset;
				got.end_at  = frames_if.frame_end_offset;
				got.atoms   = frames_if.atom_count;
				if (frame_q.size() == 0) begin
					$display("%0t: frame record expected none, got line %0d count %0d",
						$time, got.line_at, $signed(got.atoms));
					errors++;
				end else begin
					want = frame_q.pop_front();
					check_field("count_line_offset", want.line_at, got.line_at);
					check_field("header_offset", want.head_at, got.head_at);
					check_field("data_offset", want.data_at, got.data_at);
					check_field("frame_end_offset", want.end_at, got.end_at);
					check_field("atom_count", $signed(want.atoms), $signed(got.atoms));
					records_ok++;
					if ($signed(want.atoms) <= 0)
						nonpos_frames++;
				end
			end
			stall_cycles = moved ? 0 : stall_cycles + 1;
		end
	end

	function automatic logic [7:0] any_but_newline();
		logic [7:0] v;
		do v = 8'($urandom_range(0, 255)); while (v == CH_NEWLINE);
		return v;
	endfunction

	task automatic add_line(input int maxlen);
		repeat ($urandom_range(0, maxlen)) draft_put(any_but_newline());
		draft_put(CH_NEWLINE);
	endtask

	// Frame: count line, header, then as many data lines as a short count asks; a long count gets none
	task automatic add_frame();
		int r;
		int val;
		bit neg;
		repeat ($urandom_range(0, 2)) begin
			r = $urandom_range(0, 2);
			draft_put(r == 0 ? CH_SPACE : (r == 1 ? CH_TAB : CH_CR));
		end
		r   = $urandom_range(0, 3);
		neg = (r == 1);
		if (r == 0)
			draft_put(CH_PLUS);
		else if (r == 1)
			draft_put(CH_MINUS);
		if ($urandom_range(0, 9) == 0) begin
			// long count, usually saturating; the final byte closes the frame
			repeat ($urandom_range(7, 10)) draft_put(8'(CH_ZERO + $urandom_range(0, 9)));
			val = 0;
		end else begin
			if ($urandom_range(0, 8) == 0)
				repeat ($urandom_range(1, 3)) draft_put(CH_ZERO);
			val = $urandom_range(0, 3);
			draft_put(8'(CH_ZERO + val));
		end
		if ($urandom_range(0, 3) == 0) begin
			draft_put(CH_SPACE);
			add_line(3);
		end else begin
			draft_put(CH_NEWLINE);
		end
		add_line(6);
		if (!neg)
			repeat (val) add_line(6);
	endtask

	task automatic add_noise();
		logic [7:0] v;
		case ($urandom_range(0, 4))
			0: draft_put(CH_NEWLINE);
			1: begin
				do v = any_but_newline();
				while (v == CH_SPACE || v == CH_TAB || v == CH_CR || v == CH_PLUS
					|| v == CH_MINUS || (v >= CH_ZERO && v <= CH_NINE));
				draft_put(v);
				add_line(5);
			end
			2: begin
				draft_put($urandom_range(0, 1) ? CH_PLUS : CH_MINUS);
				draft_put(CH_NEWLINE);
			end
			3: begin
				draft_put(CH_TAB);
				draft_put(CH_SPACE);
				draft_put(CH_CR);
				draft_put(CH_NEWLINE);
			end
			default: repeat ($urandom_range(1, 8)) draft_put(8'($urandom_range(0, 255)));
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic fin);
		text_item_t itm;
		itm.b   = b;
		itm.fin = fin;
		pend_q = {pend_q, itm};
		bytes_queued++;
	endtask

	task automatic queue_text(input string s, input bit fin);
		for (int i = 0; i < s.len(); i++)
			queue_byte(s[i], fin && i == s.len() - 1);
	endtask

	// One buffer of frames and noise, cut short now and then so the final byte lands mid-frame
	task automatic queue_buffer();
		int cut;
		draft.delete();
		repeat ($urandom_range(1, 4)) begin
			if ($urandom_range(0, 3) == 0)
				add_noise();
			else
				add_frame();
		end
		cut = draft.size();
		if ($urandom_range(0, 9) < 3)
			cut = $urandom_range(1, draft.size());
		for (int i = 0; i < cut; i++)
			queue_byte(draft[i], i == cut - 1);
		buffers_sent++;
	endtask

	task automatic wait_drained();
		while (pend_q.size() != 0 || taken_cnt != sent_cnt || frame_q.size() != 0)
			@(posedge clk);
	endtask

	initial begin : watchdog
		while (stall_cycles < STALL_LIMIT)
			@(posedge clk);
		$display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
		$display("Verification failed");
		$finish;
	end

	initial begin : stimulus
		feed_if.valid      = 1'b0;
		feed_if.text_byte  = 8'h00;
		feed_if.final_byte = 1'b0;
		frames_if.ready    = 1'b0;
		arst_n             = 1'b0;
		scan_reset();
		snd_idle_pct = 13;
		rcv_idle_pct = 47;
		repeat (5) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;
		@(posedge clk);

		// Negative count, header with 0xFF, skip line, one data line with a NUL,
		// zero count, final byte inside the digits, then a saturated count cut at the header
		queue_text(" -3x\nh\377\n", 1'b0);
		queue_text("#\n", 1'b0);
		queue_text("\t+1\n\n", 1'b0);
		queue_byte(8'h00, 1'b0);
		queue_text("\n0\n\n7", 1'b1);
		queue_text("9999999\nh", 1'b1);
		buffers_sent += 2;

		while (bytes_queued < 420)
			queue_buffer();
		wait_drained();

		snd_idle_pct = 47;
		rcv_idle_pct = 13;
		while (bytes_queued < 840)
			queue_buffer();
		wait_drained();

		// No idling; stall the receiver long enough to back up the input
		snd_idle_pct = 0;
		rcv_idle_pct = 0;
		while (bytes_queued < 1000)
			queue_buffer();
		hold_req_seq++;
		while (bytes_queued < 1250)
			queue_buffer();
		wait_drained();
		repeat (8) @(posedge clk);

		$display("Streamed %0d bytes in %0d buffers; %0d frame records matched,",
			taken_cnt, buffers_sent, records_ok);
		$display("%0d with count <= 0. Idle mixes 13/47, 47/13 and 0/0 percent, one %0d-cycle hold.",
			nonpos_frames, HOLD_LEN);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
sv/xyzfbi_pkg.sv
sv/xyzfbi_in_if.sv
sv/xyzfbi_out_if.sv
sv/xyzfbi_in_stage.sv
sv/xyzfbi_scanner.sv
sv/xyzfbi_out_stage.sv
sv/xyz_frame_boundary_indexer.sv
bench/testbench.sv
